[design/ktmix_pkg.sv]
// ----------------------------------------------------------------------------
// ktmix_pkg: shared types and constants of the key teleop drive mixer
// Fixed-point levels, key codes, decoded key commands and the digit table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ktmix_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int LEVEL_W = 15;
	localparam int DRIVE_W = 16;
	localparam int MUL_W   = 16;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int PADDR_W = 4;
	localparam int REG_LSB = 2;

	// Unsigned Q.14 levels.
	localparam logic [LEVEL_W-1:0] Q_ONE      = 15'd16384;
	localparam logic [LEVEL_W-1:0] STEP_TENTH = 15'd1638;
	localparam logic [LEVEL_W-1:0] SPEED_MIN  = 15'd1638;
	localparam logic [LEVEL_W-1:0] TRIM_MIN   = 15'd8192;
	localparam logic [LEVEL_W-1:0] TRIM_MAX   = 15'd24576;
	localparam logic [LEVEL_W-1:0] TURN_Q     = 15'd6554;

	localparam logic [15:0]        TIMEOUT_RST = 16'd550;
	localparam logic [LEVEL_W-1:0] SPEED_RST   = 15'd8192;
	localparam logic [LEVEL_W-1:0] TRIM_RST    = 15'd16384;

	// x / 10 == (x * 52429) >> 19 for every 16-bit x.
	localparam logic [MUL_W-1:0] DIV10_RECIP = 16'd52429;
	localparam int               DIV10_SHIFT = 19;
	localparam logic [MUL_W-1:0] CURVE_BIAS  = 16'd5;

	localparam logic [PROD_W-1:0] ROUND_HALF = 32'd8192;
	localparam int                Q_SHIFT    = 14;

	localparam logic [7:0] KEY_ESC    = 8'h1B;
	localparam logic [7:0] KEY_CTRL_C = 8'h03;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_STOP,
		OP_SPEED_UP,
		OP_SPEED_DOWN,
		OP_SPEED_SET,
		OP_PRESS,
		OP_LTRIM_DOWN,
		OP_LTRIM_UP,
		OP_RTRIM_DOWN,
		OP_RTRIM_UP,
		OP_MODE
	} key_op_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT     = 2'd0,
		REG_START_SPEED = 2'd1,
		REG_START_LTRIM = 2'd2,
		REG_START_RTRIM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		key_op_t            op;
		dir_t               dir;
		logic [LEVEL_W-1:0] speed;
	} key_cmd_t;

	// Speed preset for digit keys: round(d * 16384 / 9).
	function automatic logic [LEVEL_W-1:0] digit_speed(input logic [3:0] digit);
		logic [LEVEL_W-1:0] s;
		case (digit)
			4'd1:    s = 15'd1820;
			4'd2:    s = 15'd3641;
			4'd3:    s = 15'd5461;
			4'd4:    s = 15'd7282;
			4'd5:    s = 15'd9102;
			4'd6:    s = 15'd10923;
			4'd7:    s = 15'd12743;
			4'd8:    s = 15'd14564;
			4'd9:    s = 15'd16384;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[design/ktmix_ifs.sv]
// ----------------------------------------------------------------------------
// ktmix_ifs: stream channels of the key teleop drive mixer
// Input channel carries key events and ticks; output channel carries drives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ktmix_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] time_ms;
	logic [3:0]  byte_count;
	logic [7:0]  first_byte;
	logic [7:0]  second_byte;
	logic [7:0]  third_byte;

	modport source (
		output valid, kind, time_ms, byte_count, first_byte, second_byte, third_byte,
		input  ready
	);
	modport sink (
		input  valid, kind, time_ms, byte_count, first_byte, second_byte, third_byte,
		output ready
	);
endinterface

interface ktmix_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic               manual_on;

	modport source (
		output valid, left_drive, right_drive, manual_on,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, manual_on,
		output ready
	);
endinterface

[design/ktmix_key_dec.sv]
// ----------------------------------------------------------------------------
// ktmix_key_dec: key byte decoder
// Maps raw key bytes to one command: press, stop, speed, trim or mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktmix_key_dec (
	input  logic [3:0]           byte_count,
	input  logic [7:0]           first_byte,
	input  logic [7:0]           second_byte,
	input  logic [7:0]           third_byte,
	output ktmix_pkg::key_cmd_t  cmd
);

	logic arrow_lead;

	assign arrow_lead = (byte_count >= 4'd3) && (byte_count <= 4'd8) &&
		(first_byte == ktmix_pkg::KEY_ESC) && (second_byte == "[" || second_byte == "O");

	always_comb begin
		cmd.op    = ktmix_pkg::OP_NONE;
		cmd.dir   = ktmix_pkg::DIR_UP;
		cmd.speed = '0;
		if (arrow_lead) begin
			cmd.op = ktmix_pkg::OP_PRESS;
			case (third_byte)
				"A":     cmd.dir = ktmix_pkg::DIR_UP;
				"B":     cmd.dir = ktmix_pkg::DIR_DOWN;
				"C":     cmd.dir = ktmix_pkg::DIR_RIGHT;
				"D":     cmd.dir = ktmix_pkg::DIR_LEFT;
				default: cmd.op  = ktmix_pkg::OP_NONE;
			endcase
		end else if (byte_count == 4'd1) begin
			case (first_byte) inside
				"q", "Q", " ", ktmix_pkg::KEY_CTRL_C: cmd.op = ktmix_pkg::OP_STOP;
				"+", "=": cmd.op = ktmix_pkg::OP_SPEED_UP;
				"-":      cmd.op = ktmix_pkg::OP_SPEED_DOWN;
				["1":"9"]: begin
					cmd.op    = ktmix_pkg::OP_SPEED_SET;
					cmd.speed = ktmix_pkg::digit_speed(first_byte[3:0]);
				end
				"w", "W": begin
					cmd.op  = ktmix_pkg::OP_PRESS;
					cmd.dir = ktmix_pkg::DIR_UP;
				end
				"s", "S": begin
					cmd.op  = ktmix_pkg::OP_PRESS;
					cmd.dir = ktmix_pkg::DIR_DOWN;
				end
				"a", "A": begin
					cmd.op  = ktmix_pkg::OP_PRESS;
					cmd.dir = ktmix_pkg::DIR_LEFT;
				end
				"d", "D": begin
					cmd.op  = ktmix_pkg::OP_PRESS;
					cmd.dir = ktmix_pkg::DIR_RIGHT;
				end
				"u", "U": cmd.op = ktmix_pkg::OP_LTRIM_DOWN;
				"i", "I": cmd.op = ktmix_pkg::OP_LTRIM_UP;
				"o", "O": cmd.op = ktmix_pkg::OP_RTRIM_DOWN;
				"p", "P": cmd.op = ktmix_pkg::OP_RTRIM_UP;
				"m", "M": cmd.op = ktmix_pkg::OP_MODE;
				default:  cmd.op = ktmix_pkg::OP_NONE;
			endcase
		end
	end

endmodule

[design/ktmix_mul.sv]
// ----------------------------------------------------------------------------
// ktmix_mul: shared registered multiplier
// One unsigned 16 x 16 product per enabled cycle, held until the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktmix_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic [ktmix_pkg::MUL_W-1:0]         a,
	input  logic [ktmix_pkg::MUL_W-1:0]         b,
	output logic [ktmix_pkg::PROD_W-1:0]        prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

[design/key_teleop_differential_drive_mixer_core.sv]
// ----------------------------------------------------------------------------
// key_teleop_differential_drive_mixer_core: keyboard teleop drive mixer
// Sequence: a key event is applied in the cycle after its transfer, in S_KEY,
//   and the block is then ready again. A tick steps through S_AGE once per
//   direction, then S_CURVE, S_MIX, S_MUL_L, S_MUL_R and S_DONE, which waits
//   for a free output register; only then is the next item taken, as one age
//   subtractor is used four times and one multiplier three times in sequence.
// Reset: arst_n clears all presses, loads speed, trims, mode and registers
//   with their defaults at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_teleop_differential_drive_mixer_core #(
	parameter int TIME_BITS = ktmix_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ktmix_in_if.sink                      in_ch,
	ktmix_out_if.source                   out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ktmix_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int LW = ktmix_pkg::LEVEL_W;
	localparam int MW = ktmix_pkg::MUL_W;
	localparam int PW = ktmix_pkg::PROD_W;

	// The sequencer walks a tick through age, curve, mix and two scale steps.
	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_AGE,
		S_CURVE,
		S_MIX,
		S_MUL_L,
		S_MUL_R,
		S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] idx_q;

	// Configuration registers as written, and the running levels.
	logic [15:0]   timeout_q;
	logic [LW-1:0] start_speed_q;
	logic [LW-1:0] start_ltrim_q;
	logic [LW-1:0] start_rtrim_q;
	logic [LW-1:0] speed_q;
	logic [LW-1:0] ltrim_q;
	logic [LW-1:0] rtrim_q;
	logic          mode_q;

	// Press bookkeeping, one entry per direction.
	logic [TIME_BITS-1:0] press_time_q [4];
	logic [3:0]           press_valid_q;
	logic [TIME_BITS-1:0] age_q [4];
	logic [3:0]           fresh_q;
	logic [TIME_BITS-1:0] now_q;

	ktmix_pkg::key_cmd_t key_cmd;
	ktmix_pkg::key_cmd_t key_q;

	// Per-side magnitude and sign chosen by the mix step.
	logic [LW-1:0] lm_q;
	logic [LW-1:0] rm_q;
	logic          lneg_q;
	logic          rneg_q;
	logic [15:0]   left_drv_q;

	logic          out_valid_q;
	logic [15:0]   out_left_q;
	logic [15:0]   out_right_q;
	logic          out_mode_q;
	logic          out_load;

	logic          in_fire;
	logic          cfg_wr;
	logic [TIME_BITS-1:0] age_sum;
	logic          age_fresh;

	logic          mul_en;
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [PW-1:0] prod_q;
	logic [MW-1:0] curve_num;

	logic          v_pos, v_neg, h_pos, h_neg;
	logic [LW-1:0] base_lvl;
	logic [LW-1:0] curve_lvl;
	logic [LW-1:0] mix_lm, mix_rm;
	logic          mix_ln, mix_rn;

	logic [LW-1:0] cfg_v15;
	ktmix_pkg::reg_idx_t cfg_idx;

	function automatic logic [LW-1:0] sat_level(input logic [15:0] v,
		input logic [LW-1:0] lo, input logic [LW-1:0] hi);
		logic [LW-1:0] r;
		if (v < 16'(lo)) begin
			r = lo;
		end else if (v > 16'(hi)) begin
			r = hi;
		end else begin
			r = LW'(v);
		end
		return r;
	endfunction

	function automatic logic [LW-1:0] step_down(input logic [LW-1:0] v,
		input logic [LW-1:0] lo);
		return (16'(v) >= 16'(lo) + 16'(ktmix_pkg::STEP_TENTH)) ?
			LW'(v - ktmix_pkg::STEP_TENTH) : lo;
	endfunction

	// Round the Q.28 product to Q.14 half away from zero, clamp to one and apply the sign.
	function automatic logic [15:0] scale_drive(input logic [PW-1:0] prod, input logic neg);
		logic [PW-1:0] rounded;
		logic [15:0]   mag;
		rounded = (prod + ktmix_pkg::ROUND_HALF) >> ktmix_pkg::Q_SHIFT;
		mag = (rounded > PW'(ktmix_pkg::Q_ONE)) ? 16'(ktmix_pkg::Q_ONE) : 16'(rounded);
		return neg ? 16'(16'd0 - mag) : mag;
	endfunction

	ktmix_key_dec u_key_dec (
		.byte_count  (in_ch.byte_count),
		.first_byte  (in_ch.first_byte),
		.second_byte (in_ch.second_byte),
		.third_byte  (in_ch.third_byte),
		.cmd         (key_cmd)
	);

	ktmix_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Handshakes. New items are taken only between items; the output register
	// decouples the result from the next transfer on the input.
	assign in_ch.ready        = (state_q == S_IDLE);
	assign in_fire            = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.left_drive  = $signed(out_left_q);
	assign out_ch.right_drive = $signed(out_right_q);
	assign out_ch.manual_on   = out_mode_q;

	// The finished tick moves into the output register once that is free.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// Configuration port: writes land in the access cycle, no wait states.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = ktmix_pkg::reg_idx_t'(paddr[ktmix_pkg::REG_LSB +: 2]);
	assign cfg_v15 = pwdata[LW-1:0];

	always_comb begin
		unique case (cfg_idx)
			ktmix_pkg::REG_TIMEOUT:     prdata = 32'(timeout_q);
			ktmix_pkg::REG_START_SPEED: prdata = 32'(start_speed_q);
			ktmix_pkg::REG_START_LTRIM: prdata = 32'(start_ltrim_q);
			ktmix_pkg::REG_START_RTRIM: prdata = 32'(start_rtrim_q);
			default:                    prdata = '0;
		endcase
	end

	// Age of the press under the index; one subtractor serves all four.
	// The difference wraps modulo 2^TIME_BITS just as the free-running clock does.
	assign age_sum   = now_q - press_time_q[idx_q];
	assign age_fresh = press_valid_q[idx_q] && (age_sum < TIME_BITS'(timeout_q));

	// Numerator of the curve term, speed * 3 + 5, divided by ten on the multiplier.
	assign curve_num = 16'(speed_q) + 16'({speed_q, 1'b0}) + ktmix_pkg::CURVE_BIAS;

	// The shared multiplier: curve division first, then left and right scaling.
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_CURVE: begin
				mul_en = 1'b1;
				mul_a  = curve_num;
				mul_b  = ktmix_pkg::DIV10_RECIP;
			end
			S_MUL_L: begin
				mul_en = 1'b1;
				mul_a  = MW'(lm_q);
				mul_b  = MW'(ltrim_q);
			end
			S_MUL_R: begin
				mul_en = 1'b1;
				mul_a  = MW'(rm_q);
				mul_b  = MW'(rtrim_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Resolve each axis. When both opposite presses are fresh the older one
	// wins; on equal ages down and right win.
	always_comb begin
		if (fresh_q[ktmix_pkg::DIR_UP] && fresh_q[ktmix_pkg::DIR_DOWN]) begin
			v_pos = age_q[ktmix_pkg::DIR_UP] > age_q[ktmix_pkg::DIR_DOWN];
			v_neg = !v_pos;
		end else begin
			v_pos = fresh_q[ktmix_pkg::DIR_UP];
			v_neg = fresh_q[ktmix_pkg::DIR_DOWN];
		end
		if (fresh_q[ktmix_pkg::DIR_LEFT] && fresh_q[ktmix_pkg::DIR_RIGHT]) begin
			h_pos = age_q[ktmix_pkg::DIR_LEFT] > age_q[ktmix_pkg::DIR_RIGHT];
			h_neg = !h_pos;
		end else begin
			h_pos = fresh_q[ktmix_pkg::DIR_LEFT];
			h_neg = fresh_q[ktmix_pkg::DIR_RIGHT];
		end
	end

	// Mix: straight travel uses half speed on both sides, a curve slows the
	// inner side to three tenths, and a pure turn spins in place at 0.4.
	assign base_lvl  = LW'((16'(speed_q) + 16'd1) >> 1);
	assign curve_lvl = LW'(prod_q >> ktmix_pkg::DIV10_SHIFT);

	always_comb begin
		mix_lm = '0;
		mix_rm = '0;
		mix_ln = 1'b0;
		mix_rn = 1'b0;
		if (!v_pos && !v_neg && (h_pos || h_neg)) begin
			mix_lm = ktmix_pkg::TURN_Q;
			mix_rm = ktmix_pkg::TURN_Q;
			mix_ln = h_pos;
			mix_rn = h_neg;
		end else if (v_pos || v_neg) begin
			mix_lm = h_pos ? curve_lvl : base_lvl;
			mix_rm = h_neg ? curve_lvl : base_lvl;
			mix_ln = v_neg;
			mix_rn = v_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			timeout_q     <= ktmix_pkg::TIMEOUT_RST;
			start_speed_q <= ktmix_pkg::SPEED_RST;
			start_ltrim_q <= ktmix_pkg::TRIM_RST;
			start_rtrim_q <= ktmix_pkg::TRIM_RST;
			speed_q       <= ktmix_pkg::SPEED_RST;
			ltrim_q       <= ktmix_pkg::TRIM_RST;
			rtrim_q       <= ktmix_pkg::TRIM_RST;
			mode_q        <= 1'b0;
			press_valid_q <= '0;
			for (int i = 0; i < 4; i++) begin
				press_time_q[i] <= '0;
				age_q[i]        <= '0;
			end
			fresh_q       <= '0;
			now_q         <= '0;
			key_q         <= '0;
			lm_q          <= '0;
			rm_q          <= '0;
			lneg_q        <= 1'b0;
			rneg_q        <= 1'b0;
			left_drv_q    <= '0;
			out_valid_q   <= 1'b0;
			out_left_q    <= '0;
			out_right_q   <= '0;
			out_mode_q    <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						now_q <= TIME_BITS'(in_ch.time_ms);
						key_q <= key_cmd;
						idx_q <= '0;
						state_q <= in_ch.kind ? S_AGE : S_KEY;
					end
				end
				S_KEY: begin
					unique case (key_q.op)
						ktmix_pkg::OP_STOP: begin
							press_valid_q <= '0;
							for (int i = 0; i < 4; i++) begin
								press_time_q[i] <= '0;
							end
						end
						ktmix_pkg::OP_PRESS: begin
							press_time_q[key_q.dir]  <= now_q;
							press_valid_q[key_q.dir] <= 1'b1;
						end
						ktmix_pkg::OP_SPEED_UP: begin
							speed_q <= sat_level(16'(speed_q) + 16'(ktmix_pkg::STEP_TENTH),
								ktmix_pkg::SPEED_MIN, ktmix_pkg::Q_ONE);
						end
						ktmix_pkg::OP_SPEED_DOWN: begin
							speed_q <= step_down(speed_q, ktmix_pkg::SPEED_MIN);
						end
						ktmix_pkg::OP_SPEED_SET: begin
							speed_q <= key_q.speed;
						end
						ktmix_pkg::OP_LTRIM_DOWN: begin
							ltrim_q <= step_down(ltrim_q, ktmix_pkg::TRIM_MIN);
						end
						ktmix_pkg::OP_LTRIM_UP: begin
							ltrim_q <= sat_level(16'(ltrim_q) + 16'(ktmix_pkg::STEP_TENTH),
								ktmix_pkg::TRIM_MIN, ktmix_pkg::TRIM_MAX);
						end
						ktmix_pkg::OP_RTRIM_DOWN: begin
							rtrim_q <= step_down(rtrim_q, ktmix_pkg::TRIM_MIN);
						end
						ktmix_pkg::OP_RTRIM_UP: begin
							rtrim_q <= sat_level(16'(rtrim_q) + 16'(ktmix_pkg::STEP_TENTH),
								ktmix_pkg::TRIM_MIN, ktmix_pkg::TRIM_MAX);
						end
						ktmix_pkg::OP_MODE: begin
							mode_q <= !mode_q;
						end
						default: begin
						end
					endcase
					state_q <= S_IDLE;
				end
				S_AGE: begin
					age_q[idx_q]   <= age_sum;
					fresh_q[idx_q] <= age_fresh;
					idx_q          <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						state_q <= S_CURVE;
					end
				end
				S_CURVE: begin
					state_q <= S_MIX;
				end
				S_MIX: begin
					lm_q    <= mix_lm;
					rm_q    <= mix_rm;
					lneg_q  <= mix_ln;
					rneg_q  <= mix_rn;
					state_q <= S_MUL_L;
				end
				S_MUL_L: begin
					state_q <= S_MUL_R;
				end
				S_MUL_R: begin
					left_drv_q <= scale_drive(prod_q, lneg_q);
					state_q    <= S_DONE;
				end
				S_DONE: begin
					// Hold the right product until the output register is free.
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_left_q  <= left_drv_q;
						out_right_q <= scale_drive(prod_q, rneg_q);
						out_mode_q  <= mode_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Writes to the start registers also load the running level, saturated to its range.
			if (cfg_wr) begin
				unique case (cfg_idx)
					ktmix_pkg::REG_TIMEOUT: begin
						timeout_q <= pwdata[15:0];
					end
					ktmix_pkg::REG_START_SPEED: begin
						start_speed_q <= cfg_v15;
						speed_q <= sat_level(16'(cfg_v15), ktmix_pkg::SPEED_MIN, ktmix_pkg::Q_ONE);
					end
					ktmix_pkg::REG_START_LTRIM: begin
						start_ltrim_q <= cfg_v15;
						ltrim_q <= sat_level(16'(cfg_v15), ktmix_pkg::TRIM_MIN,
							ktmix_pkg::TRIM_MAX);
					end
					ktmix_pkg::REG_START_RTRIM: begin
						start_rtrim_q <= cfg_v15;
						rtrim_q <= sat_level(16'(cfg_v15), ktmix_pkg::TRIM_MIN,
							ktmix_pkg::TRIM_MAX);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Running speed never leaves its saturation range.
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q >= ktmix_pkg::SPEED_MIN) && (speed_q <= ktmix_pkg::Q_ONE))
		else $error("speed level out of range");

	// Both trims stay within their saturation range.
	a_trim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ltrim_q >= ktmix_pkg::TRIM_MIN) && (ltrim_q <= ktmix_pkg::TRIM_MAX) &&
		(rtrim_q >= ktmix_pkg::TRIM_MIN) && (rtrim_q <= ktmix_pkg::TRIM_MAX))
		else $error("trim level out of range");

	// A result appears only at the end of a tick sequence.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside the final step");

	// Presented drives are clamped to plus or minus one.
	a_drive_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(out_left_q) >= -16'sd16384) &&
			($signed(out_left_q) <= 16'sd16384) &&
			($signed(out_right_q) >= -16'sd16384) &&
			($signed(out_right_q) <= 16'sd16384))
		else $error("drive outside plus or minus one");

endmodule
